### rtl/sxlt_pkg.sv
// Shared types, codes and helper function of the shared/exclusive lock table.
package sxlt_pkg;

   // Widths of the request and response fields.
   localparam int unsigned TXN_ID_W    = 6;
   localparam int unsigned ITEM_SLOT_W = 8;
   localparam int unsigned VERDICT_W   = 2;

   // Widest item index any table size can need, and the per-item entry layout.
   localparam int unsigned SLOT_IDX_W  = 16;
   localparam int unsigned MOD_W       = 17;
   localparam int unsigned HOLDER_W    = 64;
   localparam int unsigned COUNT_W     = 7;

   // Depth of the queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Item modes as stored in the table.
   localparam logic [1:0] MODE_FREE   = 2'd0;
   localparam logic [1:0] MODE_SHARED = 2'd1;
   localparam logic [1:0] MODE_EXCL   = 2'd2;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_GRANTED = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_DENIED  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_IGNORED = 2'd2;

   // Requested lock kind.
   localparam logic KIND_SHARED = 1'b0;
   localparam logic KIND_EXCL   = 1'b1;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      logic                  kind;
      logic [TXN_ID_W-1:0]   txn;
      logic [SLOT_IDX_W-1:0] item;
   } req_entry_type;

   // One row of the item table.
   typedef struct packed {
      logic [1:0]          mode;
      logic [COUNT_W-1:0]  count;
      logic [HOLDER_W-1:0] holder;
   } item_entry_type;

   // Fill state of the queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Remainder of an 8-bit slot number by a table size, by restoring
   // subtraction; eight steps suffice since the value is below 256 times the size.
   function automatic logic [SLOT_IDX_W-1:0] reduce_slot(
      input logic [ITEM_SLOT_W-1:0] value,
      input logic [MOD_W-1:0]       modulus
   );
      logic [MOD_W+ITEM_SLOT_W-1:0] rem;
      logic [MOD_W+ITEM_SLOT_W-1:0] sub;
      rem = {{MOD_W{1'b0}}, value};
      for (int k = ITEM_SLOT_W - 1; k >= 0; k--) begin
         sub = {{ITEM_SLOT_W{1'b0}}, modulus} << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[SLOT_IDX_W-1:0];
   endfunction

endpackage

### rtl/sxlt_front.sv
// Front stage: accepts requests, reduces slot numbers and hands them to the queue.
module sxlt_front #(
   parameter int unsigned ITEM_SLOTS = 256,
   parameter int unsigned TXN_SLOTS  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [sxlt_pkg::TXN_ID_W-1:0]       req_txn_id,
   input  logic [sxlt_pkg::ITEM_SLOT_W-1:0]    req_item_slot,
   input  logic                                clearing,
   input  sxlt_pkg::queue_status_type          q_status,
   output logic                                push,
   output sxlt_pkg::req_entry_type             push_entry
);

   logic                    front_vld_ff;
   logic                    front_vld_in;
   sxlt_pkg::req_entry_type entry_ff;
   sxlt_pkg::req_entry_type entry_in;
   logic [sxlt_pkg::SLOT_IDX_W-1:0] txn_red;
   logic                    accept;

   assign push   = front_vld_ff && !q_status.full;
   assign busy   = clearing || (front_vld_ff && q_status.full);
   assign accept = start && !busy;

   always_comb begin
      txn_red        = sxlt_pkg::reduce_slot({2'b00, req_txn_id},
                                             sxlt_pkg::MOD_W'(TXN_SLOTS));
      entry_in.kind  = req_kind;
      entry_in.txn   = txn_red[sxlt_pkg::TXN_ID_W-1:0];
      entry_in.item  = sxlt_pkg::reduce_slot(req_item_slot, sxlt_pkg::MOD_W'(ITEM_SLOTS));
      front_vld_in   = accept || (front_vld_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_entry = entry_ff;

endmodule

### rtl/sxlt_queue.sv
// Short FIFO between the front and the back.
module sxlt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sxlt_pkg::req_entry_type    push_entry,
   input  logic                       pop,
   output sxlt_pkg::req_entry_type    head,
   output sxlt_pkg::queue_status_type q_status
);

   localparam int unsigned PTR_W = (sxlt_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(sxlt_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(sxlt_pkg::QUEUE_DEPTH + 1);

   sxlt_pkg::req_entry_type slots_ff [sxlt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sxlt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sxlt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = slots_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(sxlt_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

### rtl/sxlt_back.sv
// Back stage: item table, blocked flags and the read-modify-write that decides each request.
module sxlt_back #(
   parameter int unsigned ITEM_SLOTS = 256,
   parameter int unsigned TXN_SLOTS  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sxlt_pkg::req_entry_type             head,
   input  sxlt_pkg::queue_status_type          q_status,
   output logic                                pop,
   output logic                                clearing,
   output logic                                rsp_valid,
   output logic [sxlt_pkg::VERDICT_W-1:0]      rsp_verdict
);

   localparam int unsigned IDX_W = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
   localparam int unsigned TXN_W = (TXN_SLOTS > 1) ? $clog2(TXN_SLOTS) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                       state_ff;
   logic [IDX_W-1:0]                clr_idx_ff;
   sxlt_pkg::req_entry_type         cur_ff;
   sxlt_pkg::item_entry_type        rd_ff;
   logic [TXN_SLOTS-1:0]            blocked_ff;
   logic                            rsp_valid_ff;
   logic [sxlt_pkg::VERDICT_W-1:0]  rsp_verdict_ff;

   sxlt_pkg::item_entry_type        table_mem [ITEM_SLOTS];

   sxlt_pkg::item_entry_type        entry_in;
   logic [sxlt_pkg::VERDICT_W-1:0]  verdict_in;
   logic                            holds;
   logic                            owner_match;
   logic                            is_blocked;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   sxlt_pkg::item_entry_type        mem_wdata;

   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;
   assign clearing = (state_ff == ST_CLEAR);

   // Decision on the entry read in the previous cycle.
   always_comb begin
      holds       = rd_ff.holder[cur_ff.txn];
      owner_match = (rd_ff.count == {1'b0, cur_ff.txn});
      is_blocked  = blocked_ff[cur_ff.txn[TXN_W-1:0]];
      entry_in    = rd_ff;
      verdict_in  = sxlt_pkg::VERDICT_DENIED;
      if (is_blocked) begin
         verdict_in = sxlt_pkg::VERDICT_IGNORED;
      end else if (cur_ff.kind == sxlt_pkg::KIND_SHARED) begin
         if (rd_ff.mode == sxlt_pkg::MODE_FREE || rd_ff.mode == sxlt_pkg::MODE_SHARED) begin
            verdict_in    = sxlt_pkg::VERDICT_GRANTED;
            entry_in.mode = sxlt_pkg::MODE_SHARED;
            if (!holds) begin
               entry_in.holder[cur_ff.txn] = 1'b1;
               entry_in.count = rd_ff.count + sxlt_pkg::COUNT_W'(1);
            end
         end else if (owner_match) begin
            verdict_in = sxlt_pkg::VERDICT_GRANTED;
         end
      end else begin
         if (rd_ff.mode == sxlt_pkg::MODE_SHARED &&
             rd_ff.count == sxlt_pkg::COUNT_W'(1)) begin
            // Upgrade by the sole shared holder.
            if (holds) begin
               verdict_in     = sxlt_pkg::VERDICT_GRANTED;
               entry_in.mode  = sxlt_pkg::MODE_EXCL;
               entry_in.count = {1'b0, cur_ff.txn};
            end
         end else if (rd_ff.mode == sxlt_pkg::MODE_FREE) begin
            verdict_in     = sxlt_pkg::VERDICT_GRANTED;
            entry_in.mode  = sxlt_pkg::MODE_EXCL;
            entry_in.count = {1'b0, cur_ff.txn};
         end else if (rd_ff.mode != sxlt_pkg::MODE_SHARED && owner_match) begin
            verdict_in = sxlt_pkg::VERDICT_GRANTED;
         end
      end
   end

   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_EXEC);
      mem_waddr = (state_ff == ST_CLEAR) ? clr_idx_ff : cur_ff.item[IDX_W-1:0];
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : entry_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_ff <= table_mem[head.item[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         blocked_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_idx_ff   <= clr_idx_ff + IDX_W'(1);
               if (clr_idx_ff == IDX_W'(ITEM_SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (pop) begin
                  cur_ff   <= head;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff   <= 1'b1;
               rsp_verdict_ff <= verdict_in;
               if (!is_blocked && verdict_in == sxlt_pkg::VERDICT_DENIED) begin
                  blocked_ff[cur_ff.txn[TXN_W-1:0]] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

### rtl/shared_exclusive_lock_table.sv
// Top level of the shared/exclusive lock table.
//
//   Channel   Ports                                      Transfer
//   request   start, busy, req_kind/txn_id/item_slot     start high while busy low
//   response  rsp_valid, rsp_verdict                     one-cycle strobe, never held off
//
// The back reads the item entry into a register when idle, then decides, writes the
// entry back and registers the response before taking the next transaction. Requests
// pass the front register, queue, entry register and response register. After reset
// the item table is cleared one entry a cycle, all ITEM_SLOTS entries, with busy held
// high. Busy also rises when the front register holds a transaction and the two-entry
// queue is full. The receiver cannot stall, so nothing backs up from it.
module shared_exclusive_lock_table #(
   parameter int unsigned ITEM_SLOTS = 256,
   parameter int unsigned TXN_SLOTS  = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [sxlt_pkg::TXN_ID_W-1:0]       req_txn_id,
   input  logic [sxlt_pkg::ITEM_SLOT_W-1:0]    req_item_slot,
   output logic                                rsp_valid,
   output logic [sxlt_pkg::VERDICT_W-1:0]      rsp_verdict
);

   // Front to queue.
   logic                       push;
   sxlt_pkg::req_entry_type    push_entry;
   // Queue to back.
   logic                       pop;
   sxlt_pkg::req_entry_type    head;
   sxlt_pkg::queue_status_type q_status;
   // The back holds off the front whilst the table is being cleared.
   logic                       clearing;

   // The front reduces the slot numbers to the table sizes as a transaction is taken.
   sxlt_front #(
      .ITEM_SLOTS (ITEM_SLOTS),
      .TXN_SLOTS  (TXN_SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_txn_id    (req_txn_id),
      .req_item_slot (req_item_slot),
      .clearing      (clearing),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Transactions keep their order through the queue, so every decision sees the
   // table and blocked flags as left by all earlier transactions.
   sxlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // The back handles one transaction at a time, so a write to an item is always
   // complete before the next read of the table; no forwarding is needed.
   sxlt_back #(
      .ITEM_SLOTS (ITEM_SLOTS),
      .TXN_SLOTS  (TXN_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict)
   );

endmodule

### rtl/sxlt_checker.sv
// Port-level checks of the lock table, bound to the top level.
module sxlt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_kind,
   input logic [sxlt_pkg::TXN_ID_W-1:0]       req_txn_id,
   input logic [sxlt_pkg::ITEM_SLOT_W-1:0]    req_item_slot,
   input logic                                rsp_valid,
   input logic [sxlt_pkg::VERDICT_W-1:0]      rsp_verdict
);

   // The back goes idle between transactions, so strobes never touch.
   a_no_adjacent_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobes in consecutive cycles");

   // The table clear starts straight after reset and refuses requests.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("request port not busy after reset");

   // No response can come out of reset or the first cycle of the clear.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response strobe right after reset");

   // A response always carries one of the three defined verdicts.
   a_verdict_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == sxlt_pkg::VERDICT_GRANTED ||
                     rsp_verdict == sxlt_pkg::VERDICT_DENIED ||
                     rsp_verdict == sxlt_pkg::VERDICT_IGNORED))
      else $error("response with an undefined verdict");

   // An accepted transaction carries known field values.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown({req_kind, req_txn_id, req_item_slot}))
      else $error("request accepted with unknown fields");

endmodule

bind shared_exclusive_lock_table sxlt_checker u_sxlt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_kind      (req_kind),
   .req_txn_id    (req_txn_id),
   .req_item_slot (req_item_slot),
   .rsp_valid     (rsp_valid),
   .rsp_verdict   (rsp_verdict)
);
